[hdl/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
package spq_pkg;

   localparam int DEFAULT_DEPTH = 16;

   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [1:0] REQ_DUMP    = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic       insert;
      logic       remove;
      logic       rotate;
      logic       start_dump;
      logic       rsp_load;
      logic       rsp_head;
      logic [1:0] rsp_status;
      logic       rsp_last;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic dump_last;
      logic rsp_valid;
   } stat_type;

endpackage

[hdl/spq_ctrl.sv]
// Controller state machine for the sorted priority queue.
module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_type,
   output logic              req_stall,
   input  logic              rsp_stall,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic state_ff;
   logic state_in;
   logic out_free;
   logic accept;

   assign out_free  = !stat.rsp_valid || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd            = '0;
      cmd.rsp_status = spq_pkg::STATUS_OK;
      cmd.rsp_last   = 1'b1;
      state_in       = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  spq_pkg::REQ_ENQUEUE: begin
                     cmd.rsp_load = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = spq_pkg::STATUS_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                     end
                  end
                  spq_pkg::REQ_DEQUEUE: begin
                     cmd.rsp_load = 1'b1;
                     if (stat.empty) begin
                        cmd.rsp_status = spq_pkg::STATUS_EMPTY;
                     end else begin
                        cmd.remove   = 1'b1;
                        cmd.rsp_head = 1'b1;
                     end
                  end
                  spq_pkg::REQ_DUMP: begin
                     if (stat.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = spq_pkg::STATUS_EMPTY;
                     end else begin
                        cmd.start_dump = 1'b1;
                        state_in       = ST_DUMP;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_head = 1'b1;
               cmd.rotate   = 1'b1;
               cmd.rsp_last = stat.dump_last;
               if (stat.dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/spq_datapath.sv]
// Sorted entry cells, entry count, dump counter and result register.
module spq_datapath #(
   parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  spq_pkg::cmd_type    cmd,
   output spq_pkg::stat_type   stat,
   input  logic signed [31:0]  req_item_value,
   input  logic signed [31:0]  req_item_priority,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_out_value,
   output logic signed [31:0]  rsp_out_priority,
   output logic                rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [31:0] value_ff    [DEPTH];
   logic signed [31:0] value_in    [DEPTH];
   logic signed [31:0] priority_ff [DEPTH];
   logic signed [31:0] priority_in [DEPTH];
   logic [DEPTH-1:0]   less;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CW-1:0]      remain_ff;
   logic [CW-1:0]      remain_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic signed [31:0] rsp_value_ff;
   logic signed [31:0] rsp_priority_ff;
   logic               rsp_last_ff;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         less[i] = (CW'(i) < count_ff) && (priority_ff[i] < req_item_priority);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         value_in[i]    = value_ff[i];
         priority_in[i] = priority_ff[i];
         if (cmd.insert) begin
            if (!less[i]) begin
               if (i == 0 || less[(i == 0) ? 0 : i - 1]) begin
                  value_in[i]    = req_item_value;
                  priority_in[i] = req_item_priority;
               end else begin
                  value_in[i]    = value_ff[(i == 0) ? 0 : i - 1];
                  priority_in[i] = priority_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end else if (cmd.remove) begin
            if (i < DEPTH - 1) begin
               value_in[i]    = value_ff[(i < DEPTH - 1) ? i + 1 : i];
               priority_in[i] = priority_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end else if (cmd.rotate) begin
            if (CW'(i) + CW'(1) == count_ff) begin
               value_in[i]    = value_ff[0];
               priority_in[i] = priority_ff[0];
            end else if (CW'(i) < count_ff) begin
               value_in[i]    = value_ff[(i < DEPTH - 1) ? i + 1 : i];
               priority_in[i] = priority_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CW'(1);
      end
      remain_in = remain_ff;
      if (cmd.start_dump) begin
         remain_in = count_ff;
      end else if (cmd.rotate) begin
         remain_in = remain_ff - CW'(1);
      end
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         value_ff[i]    <= value_in[i];
         priority_ff[i] <= priority_in[i];
      end
      if (cmd.rsp_load) begin
         rsp_status_ff   <= cmd.rsp_status;
         rsp_last_ff     <= cmd.rsp_last;
         rsp_value_ff    <= cmd.rsp_head ? value_ff[0] : 32'sd0;
         rsp_priority_ff <= cmd.rsp_head ? priority_ff[0] : 32'sd0;
      end
      remain_ff <= remain_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.empty      = (count_ff == '0);
   assign stat.full       = (count_ff == CW'(DEPTH));
   assign stat.dump_last  = (remain_ff == CW'(1));
   assign stat.rsp_valid  = rsp_valid_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_priority = rsp_priority_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

[hdl/sorted_priority_queue_core.sv]
// Top level of the sorted priority queue: controller and datapath.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   req_type, req_item_value, req_item_priority
//   rsp       out        rsp_valid/rsp_stall   rsp_status, rsp_out_value, rsp_out_priority,
//                                              rsp_last
//
// On an enqueue or dequeue every cell compares and shifts at once; an unused code only returns an OK result.
// A dump first loads the entry count, then moves one entry per cycle by rotating the cells while rsp is not stalled.
// A new request enters in the same cycle that the previous result transfers.
// Reset empties the queue; entry contents are not cleared.
// A stall on rsp holds the result register, and requests stall while it stays full.
module sorted_priority_queue_core #(
   parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_item_value,
   input  logic signed [31:0] req_item_priority,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_out_value,
   output logic signed [31:0] rsp_out_priority,
   output logic               rsp_last
);

   spq_pkg::cmd_type  cmd;
   spq_pkg::stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_last          (rsp_last)
   );

endmodule

[sim/sorted_priority_queue_checker.sv]
// Checker for the sorted priority queue: predicts every result and compares it with the block.
module sorted_priority_queue_checker #(
   parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_item_value,
   input  logic signed [31:0] req_item_priority,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_out_value,
   input  logic signed [31:0] rsp_out_priority,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 pending_count,
   output int                 result_count,
   output int                 full_count,
   output int                 empty_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value;
      logic signed [31:0] prio;
      logic               last;
   } queue_rsp_type;

   logic signed [31:0] model_value [DEPTH];
   logic signed [31:0] model_prio [DEPTH];
   int                 model_count = 0;
   queue_rsp_type      expected_rsp [$];
   int                 errors = 0;
   int                 checked = 0;
   int                 fulls = 0;
   int                 empties = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      result_count  = 0;
      full_count    = 0;
      empty_count   = 0;
   end

   task automatic apply_request(input logic [1:0] kind, input logic signed [31:0] val,
                                input logic signed [31:0] pri);
      int pos;
      int i;
      case (kind)
         spq_pkg::REQ_ENQUEUE: begin
            if (model_count >= DEPTH) begin
               expected_rsp.push_back('{spq_pkg::STATUS_FULL, 32'sd0, 32'sd0, 1'b1});
               fulls++;
            end else begin
               pos = 0;
               while (pos < model_count && model_prio[pos] < pri) pos++;
               for (i = model_count; i > pos; i--) begin
                  model_value[i] = model_value[i - 1];
                  model_prio[i]  = model_prio[i - 1];
               end
               model_value[pos] = val;
               model_prio[pos]  = pri;
               model_count++;
               expected_rsp.push_back('{spq_pkg::STATUS_OK, 32'sd0, 32'sd0, 1'b1});
            end
         end
         spq_pkg::REQ_DEQUEUE: begin
            if (model_count == 0) begin
               expected_rsp.push_back('{spq_pkg::STATUS_EMPTY, 32'sd0, 32'sd0, 1'b1});
               empties++;
            end else begin
               expected_rsp.push_back('{spq_pkg::STATUS_OK, model_value[0], model_prio[0],
                                        1'b1});
               for (i = 0; i + 1 < model_count; i++) begin
                  model_value[i] = model_value[i + 1];
                  model_prio[i]  = model_prio[i + 1];
               end
               model_count--;
            end
         end
         spq_pkg::REQ_DUMP: begin
            if (model_count == 0) begin
               expected_rsp.push_back('{spq_pkg::STATUS_EMPTY, 32'sd0, 32'sd0, 1'b1});
               empties++;
            end else begin
               for (i = 0; i < model_count; i++)
                  expected_rsp.push_back('{spq_pkg::STATUS_OK, model_value[i], model_prio[i],
                                           (i + 1 == model_count)});
            end
         end
         default: begin
            expected_rsp.push_back('{spq_pkg::STATUS_OK, 32'sd0, 32'sd0, 1'b1});
         end
      endcase
   endtask

   task automatic compare_result();
      queue_rsp_type want;
      checked++;
      if (expected_rsp.size() == 0) begin
         errors++;
         $display("%0t ns: result with nothing expected, status %0d value %0d",
                  $time, rsp_status, rsp_out_value);
         $display("%0t ns: unexpected result priority %0d last %0b",
                  $time, rsp_out_priority, rsp_last);
      end else begin
         want = expected_rsp.pop_front();
         if (rsp_status !== want.status) begin
            errors++;
            $display("%0t ns: rsp_status expected %0d, actual %0d",
                     $time, want.status, rsp_status);
         end
         if (rsp_out_value !== want.value) begin
            errors++;
            $display("%0t ns: rsp_out_value expected %0d, actual %0d",
                     $time, want.value, rsp_out_value);
         end
         if (rsp_out_priority !== want.prio) begin
            errors++;
            $display("%0t ns: rsp_out_priority expected %0d, actual %0d",
                     $time, want.prio, rsp_out_priority);
         end
         if (rsp_last !== want.last) begin
            errors++;
            $display("%0t ns: rsp_last expected %0b, actual %0b",
                     $time, want.last, rsp_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         model_count = 0;
         expected_rsp.delete();
      end else begin
         if (req_valid && !req_stall)
            apply_request(req_type, req_item_value, req_item_priority);
         if (rsp_valid && !rsp_stall)
            compare_result();
      end
      fail_count    <= errors;
      pending_count <= expected_rsp.size();
      result_count  <= checked;
      full_count    <= fulls;
      empty_count   <= empties;
   end

endmodule

[sim/sorted_priority_queue_core_tb.sv]
// Testbench top for the sorted priority queue: stimulus, flow control and verdict.
module sorted_priority_queue_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         QUEUE_DEPTH  = spq_pkg::DEFAULT_DEPTH;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 300;
   localparam int         QUIET_ITEMS  = 60;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         CYCLE_LIMIT  = 500000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = spq_pkg::REQ_ENQUEUE;
   logic signed [31:0] req_item_value = '0;
   logic signed [31:0] req_item_priority = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_out_value;
   logic signed [31:0] rsp_out_priority;
   logic               rsp_last;

   int fail_count;
   int pending_count;
   int result_count;
   int full_count;
   int empty_count;

   bit idle_on = 1'b1;
   int sent_count [4] = '{0, 0, 0, 0};
   int cycle_count = 0;

   sorted_priority_queue_core #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_last          (rsp_last)
   );

   sorted_priority_queue_checker #(.DEPTH(QUEUE_DEPTH)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .result_count      (result_count),
      .full_count        (full_count),
      .empty_count       (empty_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Called just after a rising edge; returns after the transfer, maybe after an idle gap.
   task automatic send_request(input logic [1:0] kind, input logic [31:0] val,
                               input logic [31:0] pri);
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_item_value    <= val;
      req_item_priority <= pri;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count[kind]++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_priority();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4)
         return $urandom_range(0, 7) - 4;
      else if (sel < 8)
         return $urandom;
      else
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
   endfunction

   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending_count);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int          n;
      int          roll;
      bit          filling;
      int          phase_left;
      logic [1:0]  kind;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_request(spq_pkg::REQ_DEQUEUE, $urandom, $urandom);
      send_request(spq_pkg::REQ_DUMP, $urandom, $urandom);
      send_request(REQ_UNUSED, $urandom, $urandom);
      send_request(spq_pkg::REQ_ENQUEUE, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(spq_pkg::REQ_ENQUEUE, 32'h8000_0000, 32'h8000_0000);
      send_request(spq_pkg::REQ_ENQUEUE, 32'd1, 32'd0);
      send_request(spq_pkg::REQ_ENQUEUE, 32'd2, 32'd0);
      send_request(spq_pkg::REQ_ENQUEUE, 32'hffff_ffff, 32'hffff_ffff);
      send_request(spq_pkg::REQ_DUMP, $urandom, $urandom);
      send_request(spq_pkg::REQ_DEQUEUE, $urandom, $urandom);
      for (n = 4; n < QUEUE_DEPTH; n++)
         send_request(spq_pkg::REQ_ENQUEUE, $urandom,
                      (n % 3 == 0) ? 32'h7fff_ffff : n * 5 - 30);
      send_request(spq_pkg::REQ_ENQUEUE, $urandom, $urandom);
      send_request(spq_pkg::REQ_DUMP, $urandom, $urandom);
      send_request(spq_pkg::REQ_DEQUEUE, $urandom, $urandom);

      filling    = 1'b0;
      phase_left = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS)
            idle_on = 1'b0;
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(20, 40);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 3)
            kind = REQ_UNUSED;
         else if (roll < 15)
            kind = spq_pkg::REQ_DUMP;
         else if (roll < 35)
            kind = filling ? spq_pkg::REQ_DEQUEUE : spq_pkg::REQ_ENQUEUE;
         else
            kind = filling ? spq_pkg::REQ_ENQUEUE : spq_pkg::REQ_DEQUEUE;
         send_request(kind, $urandom, pick_priority());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d enqueues, %0d dequeues, %0d dumps and %0d unused codes.",
               sent_count[spq_pkg::REQ_ENQUEUE], sent_count[spq_pkg::REQ_DEQUEUE],
               sent_count[spq_pkg::REQ_DUMP], sent_count[REQ_UNUSED]);
      $display("Checked %0d results, %0d of them full and %0d empty, with %0d mismatches.",
               result_count, full_count, empty_count, fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
